// ===== rtl/gb55_pkg.sv =====
// shared types, widths and the tap class function for the 5x5 rgb gaussian blur
// no dependencies
package gb55_pkg;

    localparam int DIM_W      = 12;   // frame width / height registers
    localparam int EXT_W      = 14;   // room for 2*width+2 and dimension compares
    localparam int WGT_W      = 17;   // q1.16 weight, below 2.0
    localparam int CH_W       = 8;
    localparam int NCH        = 3;
    localparam int PIX_W      = NCH * CH_W;
    localparam int NCLASS     = 6;
    localparam int TAPS       = 5;
    localparam int HIST_ROWS  = TAPS - 1;
    localparam int CSUM_W     = 11;   // up to 8 pixels of 8 bits
    localparam int PROD_W     = CSUM_W + WGT_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_W     = 16;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int CNT_W      = FIFO_AW + 2;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef logic [WGT_W-1:0] weight_t;
    typedef logic [CSUM_W-1:0] csum_t;
    typedef logic [PROD_W-1:0] prod_t;

    typedef enum logic [2:0] {
        CFG_WIDTH,
        CFG_HEIGHT,
        CFG_W_CENTER,
        CFG_W_EDGE1,
        CFG_W_DIAG1,
        CFG_W_EDGE2,
        CFG_W_KNIGHT,
        CFG_W_DIAG2
    } cfg_idx_t;

    // control that travels with each position through the datapath
    typedef struct packed {
        logic            emit;
        logic            last;
        logic [TAPS-1:0] row_ok;   // index 0 is the newest row (dy = +2)
        logic [TAPS-1:0] col_ok;   // index 0 is the newest column (dx = +2)
    } meta_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            last;
    } result_t;

    // weight class of a tap from its squared distance to the center
    function automatic logic [2:0] tap_class(input int i, input int j);
        int d2;
        begin
            d2 = (i - 2) * (i - 2) + (j - 2) * (j - 2);
            unique case (d2)
                0:       tap_class = 3'd0;
                1:       tap_class = 3'd1;
                2:       tap_class = 3'd2;
                4:       tap_class = 3'd3;
                5:       tap_class = 3'd4;
                default: tap_class = 3'd5;
            endcase
        end
    endfunction

endpackage

// ===== rtl/gb55_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies
module gb55_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/gb55_linebuf.sv =====
// column history memory (four older rows per column) and the 5x5 window
// depends on gb55_pkg and gb55_ram
module gb55_linebuf #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          accept,
    input  logic [$clog2(MAX_WIDTH)-1:0]                  col,
    input  gb55_pkg::pixel_t                              pix,
    output gb55_pkg::pixel_t [gb55_pkg::TAPS-1:0][gb55_pkg::TAPS-1:0] win
);
    import gb55_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HIST_W = HIST_ROWS * PIX_W;

    logic              s1_valid_reg;
    logic [CW-1:0]     s1_col_reg;
    pixel_t            s1_pix_reg;
    logic              fwd_reg;
    logic [HIST_W-1:0] fwd_data_reg;
    logic [HIST_W-1:0] rdata;
    logic [HIST_W-1:0] old_hist;
    logic [HIST_W-1:0] new_hist;
    pixel_t [TAPS-1:0] col_vec;
    pixel_t [TAPS-1:0][TAPS-1:0] win_reg;

    gb55_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_WIDTH)
    ) u_hist_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (new_hist),
        .re    (accept),
        .raddr (col),
        .rdata (rdata)
    );

    // a read issued in the same cycle as a write to that column sees old data, so the new history is forwarded
    always_comb
    begin
        old_hist = fwd_reg ? fwd_data_reg : rdata;
        new_hist = {old_hist[(HIST_ROWS-1)*PIX_W-1:0], s1_pix_reg};
        col_vec[0] = s1_pix_reg;
        for (int i = 1; i < TAPS; i++)
        begin
            col_vec[i] = old_hist[(i-1)*PIX_W +: PIX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= col;
            s1_pix_reg   <= pix;
            fwd_reg      <= s1_valid_reg && (s1_col_reg == col);
            fwd_data_reg <= new_hist;
        end
        if (s1_valid_reg)
        begin
            win_reg[0] <= col_vec;
            for (int j = 1; j < TAPS; j++)
            begin
                win_reg[j] <= win_reg[j-1];
            end
        end
    end

    assign win = win_reg;
endmodule

// ===== rtl/gb55_mac.sv =====
// weighted sum of the window: class sums, per-class products, final add and clamp
// depends on gb55_pkg
module gb55_mac #(
    parameter int WIN_SIZE = 5
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  gb55_pkg::pixel_t [gb55_pkg::TAPS-1:0][gb55_pkg::TAPS-1:0] win,
    input  gb55_pkg::meta_t                               meta,
    input  gb55_pkg::weight_t [gb55_pkg::NCLASS-1:0]      weights,
    output logic                                          push,
    output gb55_pkg::result_t                             result,
    output logic [1:0]                                    inflight
);
    import gb55_pkg::*;

    localparam int RAD = (WIN_SIZE / 2 > 2) ? 2 : WIN_SIZE / 2;

    logic [TAPS-1:0][TAPS-1:0]        tap_ok;
    csum_t [NCH-1:0][NCLASS-1:0]      csum_next;
    csum_t [NCH-1:0][NCLASS-1:0]      csum_reg;
    prod_t [NCH-1:0][NCLASS-1:0]      prod_next;
    prod_t [NCH-1:0][NCLASS-1:0]      prod_reg;
    logic                             v3_reg;
    logic                             v4_reg;
    logic                             last3_reg;
    logic                             last4_reg;
    logic [NCH-1:0][ACC_W-1:0]        acc;
    logic [NCH-1:0][CH_W-1:0]         chan;

    // stage 2: masked pixel sums per weight class
    always_comb
    begin
        for (int j = 0; j < TAPS; j++)
        begin
            for (int i = 0; i < TAPS; i++)
            begin
                tap_ok[j][i] = meta.row_ok[i] & meta.col_ok[j]
                             & ((i - 2) <= RAD) & ((2 - i) <= RAD)
                             & ((j - 2) <= RAD) & ((2 - j) <= RAD);
            end
        end
        csum_next = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int j = 0; j < TAPS; j++)
            begin
                for (int i = 0; i < TAPS; i++)
                begin
                    if (tap_ok[j][i])
                    begin
                        csum_next[ch][tap_class(i, j)] = csum_next[ch][tap_class(i, j)]
                            + CSUM_W'(win[j][i][CH_W*(NCH-1-ch) +: CH_W]);
                    end
                end
            end
        end
    end

    // stage 3: one multiplier per channel and class
    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            for (int k = 0; k < NCLASS; k++)
            begin
                prod_next[ch][k] = PROD_W'(csum_reg[ch][k]) * PROD_W'(weights[k]);
            end
        end
    end

    // stage 4: add the classes, drop the fraction, clamp
    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            acc[ch] = '0;
            for (int k = 0; k < NCLASS; k++)
            begin
                acc[ch] = acc[ch] + ACC_W'(prod_reg[ch][k]);
            end
            if (acc[ch][ACC_W-1:FRAC_W+CH_W] != '0)
            begin
                chan[ch] = '1;
            end
            else
            begin
                chan[ch] = acc[ch][FRAC_W +: CH_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= meta.emit;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        csum_reg  <= csum_next;
        last3_reg <= meta.last;
        prod_reg  <= prod_next;
        last4_reg <= last3_reg;
    end

    assign push         = v4_reg;
    assign result.red   = chan[0];
    assign result.green = chan[1];
    assign result.blue  = chan[2];
    assign result.last  = last4_reg;
    assign inflight     = 2'(v3_reg) + 2'(v4_reg);
endmodule

// ===== rtl/gb55_ofifo.sv =====
// small output queue that decouples the datapath from the result consumer
// depends on gb55_pkg
module gb55_ofifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  gb55_pkg::result_t             wdata,
    input  logic                          pop,
    output logic                          not_empty,
    output gb55_pkg::result_t             rdata,
    output logic [gb55_pkg::FIFO_AW:0]    count
);
    import gb55_pkg::*;

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     cnt_reg;
    logic                 do_pop;

    assign do_pop = pop && (cnt_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem_reg[rd_ptr_reg];
    assign count     = cnt_reg;
endmodule

// ===== rtl/gaussian_blur_5x5_rgb_top.sv =====
// streaming 5x5 gaussian blur, rgb, raster order, one pixel word per clock
// path to out_valid: history ram read, window register, class-sum and product registers, queue count
// throughput: one word per cycle; input stalls only when the 8-entry result queue plus
// the words in the datapath would fill it; the single history ram port pair sets this
// reset (async, active low): 640x480, center weight 1.0, others 0, frame position zero
// depends on gb55_pkg, gb55_linebuf, gb55_mac, gb55_ofifo
module gaussian_blur_5x5_rgb_top #(
    parameter int MAX_WIDTH   = 2048,
    parameter int MAX_HEIGHT  = 2048,
    parameter int WIN_SIZE    = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [2:0]                   cfg_index,
    input  logic [gb55_pkg::WGT_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [7:0]                   red_in,
    input  logic [7:0]                   green_in,
    input  logic [7:0]                   blue_in,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   red_out,
    output logic [7:0]                   green_out,
    output logic [7:0]                   blue_out,
    output logic                         last_pixel
);
    import gb55_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // configuration
    logic [DIM_W-1:0]        fw_reg, fw_next;
    logic [DIM_W-1:0]        fh_reg, fh_next;
    weight_t [NCLASS-1:0]    weights_reg, weights_next;

    // input side position and center (output) position
    logic [CW-1:0]           in_col_reg, in_col_next;
    logic [EXT_W-1:0]        lag_cnt_reg, lag_cnt_next;
    logic [CW-1:0]           ccol_reg, ccol_next;
    logic [RW-1:0]           crow_reg, crow_next;

    meta_t                   meta_now, meta1_reg, meta1_next, meta2_reg;

    logic [DIM_W-1:0]        w_eff, h_eff;
    logic [EXT_W-1:0]        w_ext, h_ext, ccol_ext, crow_ext, lag;
    logic                    emit, at_last, in_accept;
    pixel_t                  pix;
    pixel_t [TAPS-1:0][TAPS-1:0] win;
    logic                    mac_push;
    result_t                 mac_result, out_word;
    logic [1:0]              mac_inflight;
    logic [FIFO_AW:0]        fifo_cnt;
    logic [CNT_W-1:0]        pending;

    // effective frame size: zero reads as one, oversize clamps to the maximum
    always_comb
    begin
        if (fw_reg == '0)
        begin
            w_eff = DIM_W'(1);
        end
        else if (EXT_W'(fw_reg) > EXT_W'(MAX_WIDTH))
        begin
            w_eff = DIM_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_reg;
        end
        if (fh_reg == '0)
        begin
            h_eff = DIM_W'(1);
        end
        else if (EXT_W'(fh_reg) > EXT_W'(MAX_HEIGHT))
        begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = fh_reg;
        end
    end

    assign w_ext    = EXT_W'(w_eff);
    assign h_ext    = EXT_W'(h_eff);
    assign ccol_ext = EXT_W'(ccol_reg);
    assign crow_ext = EXT_W'(crow_reg);
    // a center pixel is complete once the stream is two rows and two pixels ahead
    assign lag      = EXT_W'({w_eff, 1'b0}) + EXT_W'(2);
    assign emit     = (lag_cnt_reg == lag);
    assign at_last  = emit && (ccol_ext == w_ext - 1'b1) && (crow_ext == h_ext - 1'b1);

    // credit check: every word in the datapath already owns a queue slot
    assign pending   = CNT_W'(fifo_cnt) + CNT_W'(meta1_reg.emit) + CNT_W'(meta2_reg.emit)
                     + CNT_W'(mac_inflight);
    assign in_stall  = (pending >= CNT_W'(FIFO_DEPTH));
    assign in_accept = in_valid && !in_stall;

    // drain ticks enter the history as black
    assign pix = req_type ? '0 : {red_in, green_in, blue_in};

    // frame-edge masks for the window around the current center
    always_comb
    begin
        meta_now.emit      = emit;
        meta_now.last      = at_last;
        meta_now.row_ok[0] = (crow_ext + EXT_W'(2)) < h_ext;
        meta_now.row_ok[1] = (crow_ext + EXT_W'(1)) < h_ext;
        meta_now.row_ok[2] = 1'b1;
        meta_now.row_ok[3] = (crow_reg != '0);
        meta_now.row_ok[4] = (crow_ext > EXT_W'(1));
        meta_now.col_ok[0] = (ccol_ext + EXT_W'(2)) < w_ext;
        meta_now.col_ok[1] = (ccol_ext + EXT_W'(1)) < w_ext;
        meta_now.col_ok[2] = 1'b1;
        meta_now.col_ok[3] = (ccol_reg != '0);
        meta_now.col_ok[4] = (ccol_ext > EXT_W'(1));
    end

    // register writes and position counters
    always_comb
    begin
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        weights_next = weights_reg;
        in_col_next  = in_col_reg;
        lag_cnt_next = lag_cnt_reg;
        ccol_next    = ccol_reg;
        crow_next    = crow_reg;
        meta1_next   = '0;
        if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_WIDTH:
                begin
                    fw_next      = cfg_data[DIM_W-1:0];
                    in_col_next  = '0;
                    lag_cnt_next = '0;
                    ccol_next    = '0;
                    crow_next    = '0;
                end
                CFG_HEIGHT:
                begin
                    fh_next      = cfg_data[DIM_W-1:0];
                    in_col_next  = '0;
                    lag_cnt_next = '0;
                    ccol_next    = '0;
                    crow_next    = '0;
                end
                CFG_W_CENTER: weights_next[0] = cfg_data;
                CFG_W_EDGE1:  weights_next[1] = cfg_data;
                CFG_W_DIAG1:  weights_next[2] = cfg_data;
                CFG_W_EDGE2:  weights_next[3] = cfg_data;
                CFG_W_KNIGHT: weights_next[4] = cfg_data;
                CFG_W_DIAG2:  weights_next[5] = cfg_data;
            endcase
        end
        else if (in_accept)
        begin
            meta1_next = meta_now;
            if (at_last)
            begin
                // frame done, next word starts a new frame
                in_col_next  = '0;
                lag_cnt_next = '0;
                ccol_next    = '0;
                crow_next    = '0;
            end
            else
            begin
                if (EXT_W'(in_col_reg) + EXT_W'(1) >= w_ext)
                begin
                    in_col_next = '0;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (!emit)
                begin
                    lag_cnt_next = lag_cnt_reg + 1'b1;
                end
                else if (ccol_ext + EXT_W'(1) >= w_ext)
                begin
                    ccol_next = '0;
                    crow_next = crow_reg + 1'b1;
                end
                else
                begin
                    ccol_next = ccol_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg      <= DIM_W'(640);
            fh_reg      <= DIM_W'(480);
            weights_reg <= {{(NCLASS-1){WGT_W'(0)}}, WGT_W'(65536)};
            in_col_reg  <= '0;
            lag_cnt_reg <= '0;
            ccol_reg    <= '0;
            crow_reg    <= '0;
            meta1_reg   <= '0;
            meta2_reg   <= '0;
        end
        else
        begin
            fw_reg      <= fw_next;
            fh_reg      <= fh_next;
            weights_reg <= weights_next;
            in_col_reg  <= in_col_next;
            lag_cnt_reg <= lag_cnt_next;
            ccol_reg    <= ccol_next;
            crow_reg    <= crow_next;
            meta1_reg   <= meta1_next;
            meta2_reg   <= meta1_reg;   // lines up with the window update
        end
    end

    // history ram and window: ram read on accept, write-back and shift in the cycle after
    gb55_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .col    (in_col_reg),
        .pix    (pix),
        .win    (win)
    );

    // three-stage arithmetic
    gb55_mac #(
        .WIN_SIZE (WIN_SIZE)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .win      (win),
        .meta     (meta2_reg),
        .weights  (weights_reg),
        .push     (mac_push),
        .result   (mac_result),
        .inflight (mac_inflight)
    );

    // result queue toward the consumer
    gb55_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mac_push),
        .wdata     (mac_result),
        .pop       (!out_stall),
        .not_empty (out_valid),
        .rdata     (out_word),
        .count     (fifo_cnt)
    );

    assign red_out    = out_word.red;
    assign green_out  = out_word.green;
    assign blue_out   = out_word.blue;
    assign last_pixel = out_word.last;

`ifndef SYNTHESIS
    // the credit check must keep the queue from overflowing
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overcommitted");

    // the final word of a frame rewinds the position counters
    a_frame_rewind: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && at_last) |=> (in_col_reg == '0 && lag_cnt_reg == '0
                                    && ccol_reg == '0 && crow_reg == '0))
        else $error("frame position not rewound after last word");

    // center column always inside the frame
    a_ccol_range: assert property (@(posedge clk) disable iff (!rst_n)
        ccol_ext < w_ext)
        else $error("center column beyond frame width");
`endif
endmodule

// ===== tb/gaussian_blur_5x5_rgb_top_tb.sv =====
// self-checking testbench for the streaming 5x5 rgb gaussian blur
// drives raster frames with drain ticks and random gaps, checks every word against a predictor
// depends on gb55_pkg and gaussian_blur_5x5_rgb_top
module gaussian_blur_5x5_rgb_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gb55_pkg::*;

    localparam int MAX_W     = 2048;
    localparam int MAX_H     = 2048;
    localparam int HIST_SIZE = 4 * MAX_W + 5;
    localparam int SETTLE    = 12;      // idle margin after the last expected word

    // request kinds on req_type
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [2:0]          cfg_index;
    logic [WGT_W-1:0]    cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                req_type;
    logic [7:0]          red_in;
    logic [7:0]          green_in;
    logic [7:0]          blue_in;
    logic                out_valid;
    logic                out_stall;
    logic [7:0]          red_out;
    logic [7:0]          green_out;
    logic [7:0]          blue_out;
    logic                last_pixel;

    gaussian_blur_5x5_rgb_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .last_pixel (last_pixel)
    );

    // predictor state: our own copy of the registers, history and frame position
    logic [DIM_W-1:0]  shadow_width;
    logic [DIM_W-1:0]  shadow_height;
    logic [WGT_W-1:0]  shadow_weight [NCLASS];
    logic [PIX_W-1:0]  pixel_history [HIST_SIZE];
    int unsigned       cur_col;
    int unsigned       cur_row;

    result_t           blurred_q [$];
    int                fail_count;
    int                words_sent;
    int                words_checked;
    int                frames_done;

    // sender and receiver pacing controls
    bit                gaps_on;
    int                burst_left;
    int                hold_off_left;

    // ------------------------------------------------------------------
    // clock and timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic logic [7:0] sat_channel(input longint unsigned acc);
        longint unsigned v;
        v = acc >> FRAC_W;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // register write seen by the model: dimensions restart the frame
    task automatic shadow_config(input cfg_idx_t idx, input logic [WGT_W-1:0] data);
        case (idx)
            CFG_WIDTH:
            begin
                shadow_width = data[DIM_W-1:0];
                cur_col = 0;
                cur_row = 0;
            end
            CFG_HEIGHT:
            begin
                shadow_height = data[DIM_W-1:0];
                cur_col = 0;
                cur_row = 0;
            end
            default: shadow_weight[int'(idx) - 2] = data;
        endcase
    endtask

    // one accepted word: store it and, once far enough ahead, blur the lagging pixel
    task automatic blur_predict(input logic kind, input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b);
        int unsigned     w;
        int unsigned     h;
        int unsigned     lag;
        int unsigned     pos;
        int unsigned     q;
        int              crow;
        int              ccol;
        int              rr;
        int              cc;
        int              d2;
        int              cls;
        logic [PIX_W-1:0] v;
        longint unsigned sr;
        longint unsigned sg;
        longint unsigned sb;
        longint unsigned wt;
        result_t         res;
        bit              is_last;
        w   = eff_dim(shadow_width, MAX_W);
        h   = eff_dim(shadow_height, MAX_H);
        lag = 2 * w + 2;
        pos = cur_row * w + cur_col;
        pixel_history[pos % HIST_SIZE] = (kind == REQ_PIXEL) ? {r, g, b} : '0;
        is_last = 1'b0;
        if (pos >= lag)
        begin
            q    = pos - lag;
            crow = q / w;
            ccol = q % w;
            sr = 0;
            sg = 0;
            sb = 0;
            for (int dy = -2; dy <= 2; dy++)
            begin
                for (int dx = -2; dx <= 2; dx++)
                begin
                    rr = crow + dy;
                    cc = ccol + dx;
                    if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w))
                        continue;
                    v  = pixel_history[(rr * w + cc) % HIST_SIZE];
                    d2 = dx * dx + dy * dy;
                    case (d2)
                        0:       cls = 0;
                        1:       cls = 1;
                        2:       cls = 2;
                        4:       cls = 3;
                        5:       cls = 4;
                        default: cls = 5;
                    endcase
                    wt = shadow_weight[cls];
                    sr += longint'(v[23:16]) * wt;
                    sg += longint'(v[15:8]) * wt;
                    sb += longint'(v[7:0]) * wt;
                end
            end
            is_last   = (q == w * h - 1);
            res.red   = sat_channel(sr);
            res.green = sat_channel(sg);
            res.blue  = sat_channel(sb);
            res.last  = is_last;
            blurred_q.push_back(res);
        end
        if (is_last)
        begin
            cur_col = 0;
            cur_row = 0;
        end
        else if (cur_col + 1 >= w)
        begin
            cur_col = 0;
            cur_row = (cur_row + 1) & 12'hFFF;
        end
        else
            cur_col++;
    endtask

    // ------------------------------------------------------------------
    // result checker, samples at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t exp_word;
        if (rst_n && out_valid && !out_stall)
        begin
            if (blurred_q.size() == 0)
            begin
                $error("unexpected output word r=%0d g=%0d b=%0d last=%0d",
                       red_out, green_out, blue_out, last_pixel);
                fail_count++;
            end
            else
            begin
                exp_word = blurred_q.pop_front();
                words_checked++;
                if (red_out !== exp_word.red)
                begin
                    $error("red_out expected %0d actual %0d", exp_word.red, red_out);
                    fail_count++;
                end
                if (green_out !== exp_word.green)
                begin
                    $error("green_out expected %0d actual %0d", exp_word.green, green_out);
                    fail_count++;
                end
                if (blue_out !== exp_word.blue)
                begin
                    $error("blue_out expected %0d actual %0d", exp_word.blue, blue_out);
                    fail_count++;
                end
                if (last_pixel !== exp_word.last)
                begin
                    $error("last_pixel expected %0d actual %0d", exp_word.last, last_pixel);
                    fail_count++;
                end
                if (exp_word.last)
                    frames_done++;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern: randomly chosen calm, light and heavy stretches,
    // plus a forced long hold-off when asked
    // ------------------------------------------------------------------
    initial
    begin
        int stretch_left;
        int stall_pct;
        out_stall    = 1'b0;
        stretch_left = 0;
        stall_pct    = 0;
        forever
        begin
            @(negedge clk);
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(300, 30);
                case ($urandom_range(2, 0))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    default: stall_pct = 70;
                endcase
            end
            stretch_left--;
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_stall = 1'b1;
            end
            else
                out_stall = ($urandom_range(99, 0) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // sender helpers
    // ------------------------------------------------------------------

    // offer one word; valid stays up across back-to-back words in a burst
    task automatic send_word(input logic kind, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(6, 1);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(40, 1);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid = 1'b1;
        req_type = kind;
        red_in   = r;
        green_in = g;
        blue_in  = b;
        do
            @(posedge clk);
        while (in_stall);
        blur_predict(kind, r, g, b);
        words_sent++;
        @(negedge clk);
        if (!gaps_on || burst_left == 0)
            in_valid = 1'b0;
    endtask

    // sender pauses until every expected word has come out, then lets the pipe settle
    task automatic wait_idle();
        in_valid = 1'b0;
        while (blurred_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [WGT_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_write = 1'b0;
        shadow_config(idx, data);
    endtask

    task automatic load_weights(input logic [WGT_W-1:0] w0, input logic [WGT_W-1:0] w1,
                                input logic [WGT_W-1:0] w2, input logic [WGT_W-1:0] w3,
                                input logic [WGT_W-1:0] w4, input logic [WGT_W-1:0] w5);
        write_reg(CFG_W_CENTER, w0);
        write_reg(CFG_W_EDGE1,  w1);
        write_reg(CFG_W_DIAG1,  w2);
        write_reg(CFG_W_EDGE2,  w3);
        write_reg(CFG_W_KNIGHT, w4);
        write_reg(CFG_W_DIAG2,  w5);
    endtask

    // one whole frame plus its drain; noise_pct swaps in drain ticks mid frame and
    // stray pixels in the drain, pattern 0 random, 1 checker of 0/255, 2 all 255
    task automatic run_frame(input logic [DIM_W-1:0] wcfg, input logic [DIM_W-1:0] hcfg,
                             input int noise_pct, input int pattern);
        int unsigned w;
        int unsigned h;
        logic        kind;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        write_reg(CFG_WIDTH, WGT_W'(wcfg));
        write_reg(CFG_HEIGHT, WGT_W'(hcfg));
        w = eff_dim(wcfg, MAX_W);
        h = eff_dim(hcfg, MAX_H);
        for (int unsigned i = 0; i < w * h + 2 * w + 2; i++)
        begin
            kind = (i < w * h) ? REQ_PIXEL : REQ_DRAIN;
            if ($urandom_range(99, 0) < noise_pct)
                kind = ~kind;
            case (pattern)
                1:
                begin
                    r = ((i + i / w) & 1) ? 8'hFF : 8'h00;
                    g = ~r;
                    b = r;
                end
                2:
                begin
                    r = 8'hFF;
                    g = 8'hFF;
                    b = 8'hFF;
                end
                default:
                begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
            endcase
            send_word(kind, r, g, b);
        end
        wait_idle();
    endtask

    // start of a frame only, cut short by the next dimension write
    task automatic run_partial(input logic [DIM_W-1:0] wcfg, input logic [DIM_W-1:0] hcfg,
                               input int count);
        write_reg(CFG_WIDTH, WGT_W'(wcfg));
        write_reg(CFG_HEIGHT, WGT_W'(hcfg));
        for (int i = 0; i < count; i++)
            send_word(REQ_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom));
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset weights pass pixels through unchanged; smallest frames
    task automatic test_identity_small();
        run_frame(12'd3, 12'd2, 0, 0);
        run_frame(12'd0, 12'd0, 0, 0);      // zero dimensions act as one
        run_frame(12'd1, 12'd4, 0, 1);
    endtask

    // full weights on an all-255 frame, then oversized weights on a checker, then zero weights
    task automatic test_saturation();
        load_weights(17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
        run_frame(12'd5, 12'd3, 0, 2);
        load_weights(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
        run_frame(12'd4, 12'd4, 0, 1);
        load_weights(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
        run_frame(12'd3, 12'd3, 0, 0);
    endtask

    // a typical gaussian, each class alone, drain ticks inside the frame
    task automatic test_kernel_classes();
        load_weights(17'd10474, 17'd6473, 17'd4000, 17'd1520, 17'd940, 17'd133);
        run_frame(12'd6, 12'd4, 15, 0);
        for (int k = 0; k < NCLASS; k++)
        begin
            load_weights(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
            write_reg(cfg_idx_t'(k + 2), 17'd32768);
            run_frame(12'd5, 12'd5, 0, 0);
        end
    endtask

    // oversized dimensions saturate; both frames are cut short by a new width write
    task automatic test_wide_row();
        load_weights(17'd20000, 17'd9000, 17'd3000, 17'd1000, 17'd500, 17'd100);
        run_partial(12'hFFF, 12'd1, 80);    // stream never gets far enough ahead to emit
        run_partial(12'd7, 12'hFFF, 120);   // tall frame, top rows come out
        run_frame(12'd4, 12'd3, 0, 0);
    endtask

    // receiver holds off for a long stretch while the sender keeps offering words
    task automatic test_backpressure();
        load_weights(17'd16384, 17'd8192, 17'd4096, 17'd2048, 17'd1024, 17'd512);
        gaps_on = 1'b0;
        hold_off_left = 400;
        run_frame(12'd10, 12'd8, 0, 0);
        gaps_on = 1'b1;
    endtask

    // random frames, weights and noise; stops after enough words are offered
    task automatic test_random_frames();
        int start;
        start = words_sent;
        while (words_sent - start < 200)
        begin
            load_weights(WGT_W'($urandom_range(65536, 0)), WGT_W'($urandom_range(30000, 0)),
                         WGT_W'($urandom_range(20000, 0)), WGT_W'($urandom_range(10000, 0)),
                         WGT_W'($urandom_range(5000, 0)), WGT_W'($urandom_range(131071, 0)));
            run_frame(DIM_W'($urandom_range(9, 1)), DIM_W'($urandom_range(7, 1)),
                      ($urandom_range(3, 0) == 0) ? 10 : 0, 0);
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_WIDTH;
        cfg_data      = '0;
        in_valid      = 1'b0;
        req_type      = REQ_PIXEL;
        red_in        = '0;
        green_in      = '0;
        blue_in       = '0;
        fail_count    = 0;
        words_sent    = 0;
        words_checked = 0;
        frames_done   = 0;
        gaps_on       = 1'b1;
        burst_left    = 0;
        hold_off_left = 0;

        // model state matches the block's reset
        shadow_width  = 12'd640;
        shadow_height = 12'd480;
        shadow_weight[0] = 17'd65536;
        for (int k = 1; k < NCLASS; k++)
            shadow_weight[k] = '0;
        cur_col = 0;
        cur_row = 0;

        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_identity_small();
        test_saturation();
        test_kernel_classes();
        test_wide_row();
        test_backpressure();
        test_random_frames();

        wait_idle();
        $display("run covered %0d input words, %0d blurred words checked over %0d frames",
                 words_sent, words_checked, frames_done);
        $display("frames from 1x1 to 10x8 plus cut-short oversize ones, weights zero to above unity");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
